// ----- hdl/mrc_pkg.sv -----
// Shared constants, types and the CRC-16 byte step for the Modbus reply checker.
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

	// Frame geometry
	localparam int MAX_FRAME_DEF = 64;
	localparam int MIN_FRAME     = 11;

	// CRC-16 (Modbus): reflected polynomial, all-ones seed
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration register indexes and widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_LIMIT        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT       = 2'd3;

	// Configuration reset values
	localparam logic [15:0] PRESSURE_LIMIT_RST    = 16'd3600;
	localparam logic [15:0] FLOW_LIMIT_RST        = 16'd9000;
	localparam logic [15:0] TEMPERATURE_LIMIT_RST = 16'd1200;
	localparam logic [3:0]  RETRY_LIMIT_RST       = 4'd3;

	// Missed-poll counter saturation point
	localparam logic [3:0] MISSED_MAX = 4'd15;

	// Number of 16-bit values carried in a reply
	localparam int NUM_VALUES = 3;

	// Judgement of one frame-ending transaction
	typedef struct packed {
		logic                             ok;
		logic [NUM_VALUES-1:0][15:0]      values;
	} frame_res_t;

	// Limits as seen by the status logic
	typedef struct packed {
		logic [15:0] pressure_limit;
		logic [15:0] flow_limit;
		logic [15:0] temperature_limit;
		logic [3:0]  retry_limit;
	} cfg_regs_t;

	// One CRC-16 byte step, eight bit shifts unrolled
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/mrc_frame.sv -----
// Frame tracker: CRC accumulation, two-byte delay line, byte count and value capture.
`timescale 1ns / 1ps
`default_nettype none

module mrc_frame #(
	parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output mrc_pkg::frame_res_t    res
);
	import mrc_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic [15:0]                   crc_q;
	logic [7:0]                    held0_q;
	logic [7:0]                    held1_q;
	logic [CNT_W-1:0]              count_q;
	logic [NUM_VALUES-1:0][15:0]   pend_q;

	logic [15:0]                   crc_n;
	logic [7:0]                    held0_n;
	logic [7:0]                    held1_n;
	logic [CNT_W-1:0]              count_n;
	logic [NUM_VALUES-1:0][15:0]   pend_n;
	logic                          take;
	logic [2:0]                    off;
	logic                          frame_end;

	// Take the byte into the tracking state unless the frame is already full
	always_comb begin
		crc_n   = crc_q;
		held0_n = held0_q;
		held1_n = held1_q;
		count_n = count_q;
		pend_n  = pend_q;
		off     = 3'(count_q - CNT_W'(3));
		take    = (count_q < CNT_W'(MAX_FRAME));
		if (take) begin
			if (count_q >= CNT_W'(2)) begin
				crc_n = crc_byte(crc_q, held0_q);
			end
			held0_n = held1_q;
			held1_n = data_byte;
			if (count_q >= CNT_W'(3) && count_q <= CNT_W'(8)) begin
				if (!off[0]) begin
					pend_n[off[2:1]][15:8] = data_byte;
				end else begin
					pend_n[off[2:1]][7:0] = data_byte;
				end
			end
			count_n = count_q + CNT_W'(1);
		end
	end

	// Judge the frame: a reply's last byte, long enough and trailing CRC matches, low byte first
	always_comb begin
		res.ok     = !kind && last_byte && (count_n >= CNT_W'(MIN_FRAME))
		             && ({held1_n, held0_n} == crc_n);
		res.values = pend_n;
	end

	assign frame_end = kind || last_byte;

	// Advance on every transaction, return to the idle frame after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			held0_q <= '0;
			held1_q <= '0;
			count_q <= '0;
			pend_q  <= '0;
		end else if (step) begin
			if (frame_end) begin
				crc_q   <= CRC_INIT;
				held0_q <= '0;
				held1_q <= '0;
				count_q <= '0;
				pend_q  <= '0;
			end else begin
				crc_q   <= crc_n;
				held0_q <= held0_n;
				held1_q <= held1_n;
				count_q <= count_n;
				pend_q  <= pend_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mrc_status.sv -----
// Device status: committed values, alarms, missed polls, online state and counters.
`timescale 1ns / 1ps
`default_nettype none

module mrc_status (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                update,
	input  wire mrc_pkg::frame_res_t res,
	input  wire mrc_pkg::cfg_regs_t  cfg,
	output logic                     frame_ok,
	output logic [15:0]              pressure,
	output logic [15:0]              flow,
	output logic [15:0]              temperature,
	output logic                     pressure_alarm,
	output logic                     flow_alarm,
	output logic                     temperature_alarm,
	output logic                     dev_online,
	output logic                     offline_flag,
	output logic [31:0]              error_count,
	output logic [31:0]              accepted_polls
);
	import mrc_pkg::*;

	logic        frame_ok_q;
	logic [15:0] pressure_q;
	logic [15:0] flow_q;
	logic [15:0] temperature_q;
	logic        pressure_alarm_q;
	logic        flow_alarm_q;
	logic        temperature_alarm_q;
	logic        online_q;
	logic        offline_q;
	logic [31:0] error_count_q;
	logic [31:0] poll_count_q;
	logic [3:0]  missed_q;
	logic [3:0]  missed_n;

	// Saturating missed-poll increment
	assign missed_n = (missed_q < MISSED_MAX) ? missed_q + 4'd1 : missed_q;

	// Hold the status; it doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ok_q          <= 1'b0;
			pressure_q          <= '0;
			flow_q              <= '0;
			temperature_q       <= '0;
			pressure_alarm_q    <= 1'b0;
			flow_alarm_q        <= 1'b0;
			temperature_alarm_q <= 1'b0;
			online_q            <= 1'b0;
			offline_q           <= 1'b0;
			error_count_q       <= '0;
			poll_count_q        <= '0;
			missed_q            <= '0;
		end else if (update) begin
			frame_ok_q <= res.ok;
			if (res.ok) begin
				pressure_q          <= res.values[0];
				flow_q              <= res.values[1];
				temperature_q       <= res.values[2];
				pressure_alarm_q    <= res.values[0] > cfg.pressure_limit;
				flow_alarm_q        <= res.values[1] > cfg.flow_limit;
				temperature_alarm_q <= res.values[2] > cfg.temperature_limit;
				online_q            <= 1'b1;
				poll_count_q        <= poll_count_q + 32'd1;
				missed_q            <= '0;
			end else begin
				pressure_alarm_q    <= 1'b0;
				flow_alarm_q        <= 1'b0;
				temperature_alarm_q <= 1'b0;
				error_count_q       <= error_count_q + 32'd1;
				missed_q            <= missed_n;
				if (missed_n >= cfg.retry_limit) begin
					online_q  <= 1'b0;
					offline_q <= 1'b1;
				end
			end
		end
	end

	assign frame_ok          = frame_ok_q;
	assign pressure          = pressure_q;
	assign flow              = flow_q;
	assign temperature       = temperature_q;
	assign pressure_alarm    = pressure_alarm_q;
	assign flow_alarm        = flow_alarm_q;
	assign temperature_alarm = temperature_alarm_q;
	assign dev_online        = online_q;
	assign offline_flag      = offline_q;
	assign error_count       = error_count_q;
	assign accepted_polls    = poll_count_q;

endmodule

`default_nettype wire

// ----- hdl/modbus_response_checker.sv -----
// Top level of the Modbus RTU reply checker: input stage, configuration and result handshake.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per received reply byte
//   (kind 0, last_byte marks the end of the frame) or one no-reply event (kind 1).
//   A result transaction appears on the output channel (out_valid/out_ready) only at the
//   end of a frame or on a no-reply event; ordinary bytes produce no result.
//   A transaction is registered into the input stage, then passes through the CRC step
//   and frame judgement into the status register; out_valid is registered alongside the
//   status register and rises when a final byte or no-reply event reaches it.
//   Throughput: one transaction per cycle except while a frame end waits on a pending result;
//   the CRC-16 byte step is unrolled in one stage.
//   When the receiver stalls, the pending result holds in the status register and the
//   input stage keeps taking mid-frame bytes; a frame-ending transaction waits in the
//   input stage and in_ready stays low until the pending result is taken.
//   Configuration (cfg_we, cfg_index, cfg_data) writes a limit at once; write only while idle.
//   Reset clears the frame tracking, counters and status, and loads default limits.
`timescale 1ns / 1ps
`default_nettype none

module modbus_response_checker #(
	parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            kind,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 frame_ok,
	output logic [15:0]                          pressure,
	output logic [15:0]                          flow,
	output logic [15:0]                          temperature,
	output logic                                 pressure_alarm,
	output logic                                 flow_alarm,
	output logic                                 temperature_alarm,
	output logic                                 dev_online,
	output logic                                 offline_flag,
	output logic [31:0]                          error_count,
	output logic [31:0]                          accepted_polls,
	input  wire logic                            cfg_we,
	input  wire logic [mrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mrc_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	cfg_regs_t   cfg_q;
	frame_res_t  res;
	logic        has_res;
	logic        out_free;
	logic        advance;
	logic        update;

	// Handshake: hold a frame end in the input stage while the result slot is full
	assign has_res  = kind_s1 || last_s1;
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!has_res || out_free);
	assign update   = advance && has_res;
	assign in_ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_limit    <= PRESSURE_LIMIT_RST;
			cfg_q.flow_limit        <= FLOW_LIMIT_RST;
			cfg_q.temperature_limit <= TEMPERATURE_LIMIT_RST;
			cfg_q.retry_limit       <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESSURE_LIMIT: begin
					cfg_q.pressure_limit <= cfg_data;
				end
				CFG_FLOW_LIMIT: begin
					cfg_q.flow_limit <= cfg_data;
				end
				CFG_TEMPERATURE_LIMIT: begin
					cfg_q.temperature_limit <= cfg_data;
				end
				CFG_RETRY_LIMIT: begin
					cfg_q.retry_limit <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	mrc_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.kind      (kind_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	mrc_status u_status (
		.clk               (clk),
		.arst_n            (arst_n),
		.update            (update),
		.res               (res),
		.cfg               (cfg_q),
		.frame_ok          (frame_ok),
		.pressure          (pressure),
		.flow              (flow),
		.temperature       (temperature),
		.pressure_alarm    (pressure_alarm),
		.flow_alarm        (flow_alarm),
		.temperature_alarm (temperature_alarm),
		.dev_online        (dev_online),
		.offline_flag      (offline_flag),
		.error_count       (error_count),
		.accepted_polls    (accepted_polls)
	);

endmodule

`default_nettype wire
